>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, result codes and the datapath command set shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int CMD_W     = 3;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;
    localparam int CODE_W    = 2;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd5;

    // Compare results
    localparam logic [CODE_W-1:0] ORD_LESS    = 2'd0;
    localparam logic [CODE_W-1:0] ORD_EQUAL   = 2'd1;
    localparam logic [CODE_W-1:0] ORD_GREATER = 2'd2;

    // Status codes
    localparam logic [CODE_W-1:0] ST_OK       = 2'd0;
    localparam logic [CODE_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [CODE_W-1:0] ST_DIV_ZERO = 2'd2;

    // Datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_GCD_AB,
        DP_GCD_R,
        DP_DIV_EUC,
        DP_ST_EUC,
        DP_DIV_DA,
        DP_ST_QA,
        DP_DIV_DB,
        DP_ST_QB,
        DP_MUL_LCM,
        DP_MUL_TA,
        DP_MUL_TB,
        DP_SUM,
        DP_MUL_NN,
        DP_MUL_DD,
        DP_MUL_NADB,
        DP_MUL_NBDA,
        DP_MUL_DANB,
        DP_SET_RN,
        DP_MOV_A,
        DP_DIV_RN,
        DP_ST_RN,
        DP_DIV_RD,
        DP_ST_RD,
        DP_FIN_OK,
        DP_FIN_CMP,
        DP_FIN_DEN,
        DP_FIN_DIV,
        DP_FIN_NONE
    } dp_op_t;

    // Datapath status towards the controller
    typedef struct packed {
        logic             div_busy;
        logic             y_zero;
        logic             den_zero;
        logic             nb_zero;
        logic [CMD_W-1:0] cmd;
    } dp_status_t;

endpackage

>>> rtl/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle. Quotient and
// remainder hold after completion until the next start.
// ----------------------------------------------------------------------------
module rau_div #(
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        shifted   = {rem_reg, quot_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
            end else begin
                rem_next = shifted[DW-1:0];
            end
            quot_next = {quot_reg[DW-2:0], ~diff[DW]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control under reset, advance otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    property p_count_live;
        @(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0;
    endproperty
    a_count_live: assert property (p_count_live)
        else $error("divider busy with empty count");

    property p_start_busy;
        @(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == CW'(DW);
    endproperty
    a_start_busy: assert property (p_start_busy)
        else $error("divider did not start");

    property p_finish;
        @(posedge aclk) disable iff (!aresetn)
        busy_reg && !start && cnt_reg == CW'(1) |=> !busy_reg;
    endproperty
    a_finish: assert property (p_finish)
        else $error("divider overran its count");

endmodule

>>> rtl/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, Euclid registers, a shared multiplier, the shared
// divider and the result registers, all driven by controller commands.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int W = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rau_pkg::dp_op_t                    op,
    output rau_pkg::dp_status_t                status,
    input  logic [rau_pkg::CMD_W-1:0]          in_cmd,
    input  logic signed [W-1:0]                in_num_a,
    input  logic signed [W-1:0]                in_den_a,
    input  logic signed [W-1:0]                in_num_b,
    input  logic signed [W-1:0]                in_den_b,
    output logic signed [rau_pkg::NUM_OUT_W-1:0] res_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]      res_den,
    output logic [rau_pkg::CODE_W-1:0]         res_order,
    output logic [rau_pkg::CODE_W-1:0]         res_status
);

    import rau_pkg::*;

    localparam int DW = 2 * W;
    localparam int NX = (DW + 1 > NUM_OUT_W) ? DW + 1 : NUM_OUT_W;
    localparam int DX = (DW > DEN_OUT_W) ? DW : DEN_OUT_W;

    logic [CMD_W-1:0] cmd_reg;
    logic [W-1:0]     na_reg, da_reg, nb_reg, db_reg;
    logic             na_neg_reg, nb_neg_reg;
    logic [W-1:0]     qa_reg, qb_reg;
    logic [DW-1:0]    x_reg, y_reg;
    logic [DW-1:0]    ta_reg, tb_reg;
    logic [DW-1:0]    rn_reg, rd_reg;
    logic             rn_neg_reg;

    logic signed [NUM_OUT_W-1:0] res_num_reg;
    logic [DEN_OUT_W-1:0]        res_den_reg;
    logic [CODE_W-1:0]           res_order_reg, res_status_reg;

    // Input decode to sign and magnitude
    logic [W-1:0] ua_n, ua_d, ub_n, ub_d;
    logic [W-1:0] ma_n, ma_d, mb_n, mb_d;

    always_comb begin
        ua_n = in_num_a;
        ua_d = in_den_a;
        ub_n = in_num_b;
        ub_d = in_den_b;
        ma_n = ua_n[W-1] ? (~ua_n + 1'b1) : ua_n;
        ma_d = ua_d[W-1] ? (~ua_d + 1'b1) : ua_d;
        mb_n = ub_n[W-1] ? (~ub_n + 1'b1) : ub_n;
        mb_d = ub_d[W-1] ? (~ub_d + 1'b1) : ub_d;
    end

    // Shared multiplier operand selection
    logic [W-1:0]  mul_a, mul_b;
    logic [DW-1:0] prod;

    always_comb begin
        case (op)
            DP_MUL_LCM:  begin mul_a = qa_reg; mul_b = db_reg; end
            DP_MUL_TA:   begin mul_a = na_reg; mul_b = qb_reg; end
            DP_MUL_TB:   begin mul_a = nb_reg; mul_b = qa_reg; end
            DP_MUL_NN:   begin mul_a = na_reg; mul_b = nb_reg; end
            DP_MUL_DD:   begin mul_a = da_reg; mul_b = db_reg; end
            DP_MUL_NADB: begin mul_a = na_reg; mul_b = db_reg; end
            DP_MUL_NBDA: begin mul_a = nb_reg; mul_b = da_reg; end
            DP_MUL_DANB: begin mul_a = da_reg; mul_b = nb_reg; end
            default:     begin mul_a = '0;     mul_b = '0;     end
        endcase
        prod = DW'(mul_a) * DW'(mul_b);
    end

    // Shared divider operand selection
    logic          div_start;
    logic [DW-1:0] div_n, div_d;
    logic          div_busy;
    logic [DW-1:0] div_q, div_r;

    always_comb begin
        div_start = 1'b1;
        div_d     = x_reg;
        case (op)
            DP_DIV_EUC: begin div_n = x_reg; div_d = y_reg; end
            DP_DIV_DA:  div_n = DW'(da_reg);
            DP_DIV_DB:  div_n = DW'(db_reg);
            DP_DIV_RN:  div_n = rn_reg;
            DP_DIV_RD:  div_n = rd_reg;
            default: begin
                div_start = 1'b0;
                div_n     = '0;
            end
        endcase
    end

    rau_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Signed-magnitude sum for add and subtract
    logic          tb_neg;
    logic [DW-1:0] sum_mag;
    logic          sum_neg;
    logic          ta_ge;

    always_comb begin
        tb_neg = nb_neg_reg ^ ((cmd_reg == CMD_SUB) && (tb_reg != '0));
        ta_ge  = ta_reg >= tb_reg;
        if (na_neg_reg == tb_neg) begin
            sum_mag = ta_reg + tb_reg;
            sum_neg = na_neg_reg;
        end else if (ta_ge) begin
            sum_mag = ta_reg - tb_reg;
            sum_neg = na_neg_reg;
        end else begin
            sum_mag = tb_reg - ta_reg;
            sum_neg = tb_neg;
        end
    end

    // Exact compare of the cross products
    logic [CODE_W-1:0] cmp_ord;

    always_comb begin
        if (na_neg_reg != nb_neg_reg) begin
            cmp_ord = na_neg_reg ? ORD_LESS : ORD_GREATER;
        end else if (ta_reg == tb_reg) begin
            cmp_ord = ORD_EQUAL;
        end else if (na_neg_reg) begin
            cmp_ord = (ta_reg > tb_reg) ? ORD_LESS : ORD_GREATER;
        end else begin
            cmp_ord = (ta_reg > tb_reg) ? ORD_GREATER : ORD_LESS;
        end
    end

    // Result formatting
    logic [NX-1:0] num_ext;
    logic [DX-1:0] den_ext;

    always_comb begin
        num_ext = NX'(rn_reg);
        if (rn_neg_reg && rn_reg != '0) begin
            num_ext = ~num_ext + 1'b1;
        end
        den_ext = DX'(rd_reg);
    end

    // Apply commands
    always_ff @(posedge aclk) begin
        case (op)
            DP_LOAD: begin
                cmd_reg    <= in_cmd;
                na_reg     <= ma_n;
                da_reg     <= ma_d;
                nb_reg     <= mb_n;
                db_reg     <= mb_d;
                na_neg_reg <= (ua_n[W-1] ^ ua_d[W-1]) && (ma_n != '0);
                nb_neg_reg <= (ub_n[W-1] ^ ub_d[W-1]) && (mb_n != '0);
            end
            DP_GCD_AB: begin
                x_reg <= DW'(da_reg);
                y_reg <= DW'(db_reg);
            end
            DP_GCD_R: begin
                x_reg <= rn_reg;
                y_reg <= rd_reg;
            end
            DP_ST_EUC: begin
                x_reg <= y_reg;
                y_reg <= div_r;
            end
            DP_ST_QA:    qa_reg <= div_q[W-1:0];
            DP_ST_QB:    qb_reg <= div_q[W-1:0];
            DP_MUL_LCM:  rd_reg <= prod;
            DP_MUL_TA:   ta_reg <= prod;
            DP_MUL_TB:   tb_reg <= prod;
            DP_SUM: begin
                rn_reg     <= sum_mag;
                rn_neg_reg <= sum_neg;
            end
            DP_MUL_NN: begin
                rn_reg     <= prod;
                rn_neg_reg <= na_neg_reg ^ nb_neg_reg;
            end
            DP_MUL_DD:   rd_reg <= prod;
            DP_MUL_NADB: ta_reg <= prod;
            DP_MUL_NBDA: tb_reg <= prod;
            DP_MUL_DANB: rd_reg <= prod;
            DP_SET_RN: begin
                rn_reg     <= ta_reg;
                rn_neg_reg <= na_neg_reg ^ nb_neg_reg;
            end
            DP_MOV_A: begin
                rn_reg     <= DW'(na_reg);
                rn_neg_reg <= na_neg_reg;
                rd_reg     <= DW'(da_reg);
            end
            DP_ST_RN:    rn_reg <= div_q;
            DP_ST_RD:    rd_reg <= div_q;
            DP_FIN_OK: begin
                res_num_reg    <= num_ext[NUM_OUT_W-1:0];
                res_den_reg    <= den_ext[DEN_OUT_W-1:0];
                res_order_reg  <= ORD_LESS;
                res_status_reg <= ST_OK;
            end
            DP_FIN_CMP: begin
                res_num_reg    <= '0;
                res_den_reg    <= '0;
                res_order_reg  <= cmp_ord;
                res_status_reg <= ST_OK;
            end
            DP_FIN_DEN: begin
                res_num_reg    <= '0;
                res_den_reg    <= '0;
                res_order_reg  <= ORD_LESS;
                res_status_reg <= ST_ZERO_DEN;
            end
            DP_FIN_DIV: begin
                res_num_reg    <= '0;
                res_den_reg    <= '0;
                res_order_reg  <= ORD_LESS;
                res_status_reg <= ST_DIV_ZERO;
            end
            DP_FIN_NONE: begin
                res_num_reg    <= '0;
                res_den_reg    <= '0;
                res_order_reg  <= ORD_LESS;
                res_status_reg <= ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Status towards the controller
    always_comb begin
        status.div_busy = div_busy;
        status.y_zero   = (y_reg == '0);
        status.den_zero = (da_reg == '0) || ((cmd_reg != CMD_REDUCE) && (db_reg == '0));
        status.nb_zero  = (nb_reg == '0);
        status.cmd      = cmd_reg;
    end

    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign res_order  = res_order_reg;
    assign res_status = res_status_reg;

endmodule

>>> rtl/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences the datapath through each operation, the Euclid loops and the
// final reduction, and runs both handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rau_pkg::dp_status_t status,
    output rau_pkg::dp_op_t     op
);

    import rau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_GCD_AB,
        S_EUC,
        S_EUC_W,
        S_DA_G,
        S_DA_W,
        S_DB_G,
        S_DB_W,
        S_LCM,
        S_TA,
        S_TB,
        S_SUM,
        S_MNN,
        S_MDD,
        S_MNADB,
        S_MNBDA,
        S_MDANB,
        S_SETRN,
        S_MOV,
        S_RED,
        S_RN_G,
        S_RN_W,
        S_RD_G,
        S_RD_W,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    dp_op_t fin_reg, fin_next;
    logic   red_reg, red_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and datapath command
    always_comb begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        red_next     = red_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op           = DP_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op         = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_FIN;
                if (status.cmd > CMD_REDUCE) begin
                    fin_next = DP_FIN_NONE;
                end else if (status.den_zero) begin
                    fin_next = DP_FIN_DEN;
                end else if (status.cmd == CMD_DIV && status.nb_zero) begin
                    fin_next = DP_FIN_DIV;
                end else begin
                    fin_next = DP_FIN_OK;
                    case (status.cmd)
                        CMD_ADD, CMD_SUB: state_next = S_GCD_AB;
                        CMD_MUL:          state_next = S_MNN;
                        CMD_DIV:          state_next = S_MNADB;
                        CMD_CMP: begin
                            fin_next   = DP_FIN_CMP;
                            state_next = S_MNADB;
                        end
                        default:          state_next = S_MOV;
                    endcase
                end
            end
            S_GCD_AB: begin
                op         = DP_GCD_AB;
                red_next   = 1'b0;
                state_next = S_EUC;
            end
            S_EUC: begin
                if (status.y_zero) begin
                    state_next = red_reg ? S_RN_G : S_DA_G;
                end else begin
                    op         = DP_DIV_EUC;
                    state_next = S_EUC_W;
                end
            end
            S_EUC_W: begin
                if (!status.div_busy) begin
                    op         = DP_ST_EUC;
                    state_next = S_EUC;
                end
            end
            S_DA_G: begin
                op         = DP_DIV_DA;
                state_next = S_DA_W;
            end
            S_DA_W: begin
                if (!status.div_busy) begin
                    op         = DP_ST_QA;
                    state_next = S_DB_G;
                end
            end
            S_DB_G: begin
                op         = DP_DIV_DB;
                state_next = S_DB_W;
            end
            S_DB_W: begin
                if (!status.div_busy) begin
                    op         = DP_ST_QB;
                    state_next = S_LCM;
                end
            end
            S_LCM: begin
                op         = DP_MUL_LCM;
                state_next = S_TA;
            end
            S_TA: begin
                op         = DP_MUL_TA;
                state_next = S_TB;
            end
            S_TB: begin
                op         = DP_MUL_TB;
                state_next = S_SUM;
            end
            S_SUM: begin
                op         = DP_SUM;
                state_next = S_RED;
            end
            S_MNN: begin
                op         = DP_MUL_NN;
                state_next = S_MDD;
            end
            S_MDD: begin
                op         = DP_MUL_DD;
                state_next = S_RED;
            end
            S_MNADB: begin
                op         = DP_MUL_NADB;
                state_next = (status.cmd == CMD_CMP) ? S_MNBDA : S_MDANB;
            end
            S_MNBDA: begin
                op         = DP_MUL_NBDA;
                state_next = S_FIN;
            end
            S_MDANB: begin
                op         = DP_MUL_DANB;
                state_next = S_SETRN;
            end
            S_SETRN: begin
                op         = DP_SET_RN;
                state_next = S_RED;
            end
            S_MOV: begin
                op         = DP_MOV_A;
                state_next = S_RED;
            end
            S_RED: begin
                op         = DP_GCD_R;
                red_next   = 1'b1;
                state_next = S_EUC;
            end
            S_RN_G: begin
                op         = DP_DIV_RN;
                state_next = S_RN_W;
            end
            S_RN_W: begin
                if (!status.div_busy) begin
                    op         = DP_ST_RN;
                    state_next = S_RD_G;
                end
            end
            S_RD_G: begin
                op         = DP_DIV_RD;
                state_next = S_RD_W;
            end
            S_RD_W: begin
                if (!status.div_busy) begin
                    op         = DP_ST_RD;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                // Deliver only once the output slot is free
                if (!m_valid_reg || m_ready) begin
                    op           = fin_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and the output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fin_reg     <= DP_FIN_NONE;
            red_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            red_reg     <= red_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    property p_idle_div_quiet;
        @(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !status.div_busy;
    endproperty
    a_idle_div_quiet: assert property (p_idle_div_quiet)
        else $error("divider busy while idle");

    property p_fin_waits;
        @(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && m_valid_reg && !m_ready |=> state_reg == S_FIN;
    endproperty
    a_fin_waits: assert property (p_fin_waits)
        else $error("result overwrote an untaken transaction");

    property p_euc_return;
        @(posedge aclk) disable iff (!aresetn)
        state_reg == S_EUC_W && !status.div_busy |=> state_reg == S_EUC;
    endproperty
    a_euc_return: assert property (p_euc_return)
        else $error("Euclid loop lost its step");

endmodule

>>> rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide, compare or reduce two signed fractions,
// giving a fully reduced result with a positive denominator.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. Latency is data dependent and is set
// by the shared restoring divider: each division, Euclid step included, runs
// to completion between issue and store. An item's time grows with E+D, where E
// is the total number of Euclid steps and D the number of plain divisions: two
// GCDs and four divisions for add and subtract, one GCD and two divisions for
// multiply, divide and reduce. Compare and error cases run no division. A new
// transaction is taken while a result still waits on the output.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rau_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [OPERAND_WIDTH-1:0]      s_num_a,
    input  logic signed [OPERAND_WIDTH-1:0]      s_den_a,
    input  logic signed [OPERAND_WIDTH-1:0]      s_num_b,
    input  logic signed [OPERAND_WIDTH-1:0]      s_den_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rau_pkg::NUM_OUT_W-1:0] m_res_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]        m_res_den,
    output logic [rau_pkg::CODE_W-1:0]           m_order,
    output logic [rau_pkg::CODE_W-1:0]           m_status
);

    import rau_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    rau_datapath #(.W(OPERAND_WIDTH)) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .status     (status),
        .in_cmd     (s_cmd),
        .in_num_a   (s_num_a),
        .in_den_a   (s_den_a),
        .in_num_b   (s_num_b),
        .in_den_b   (s_den_b),
        .res_num    (m_res_num),
        .res_den    (m_res_den),
        .res_order  (m_order),
        .res_status (m_status)
    );

endmodule

>>> tb/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit result checker
// Watches both channels, works out the reduced fraction, order and status
// for every accepted operand transaction and compares each result in turn.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [rau_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [OPERAND_WIDTH-1:0]      s_num_a,
    input  logic signed [OPERAND_WIDTH-1:0]      s_den_a,
    input  logic signed [OPERAND_WIDTH-1:0]      s_num_b,
    input  logic signed [OPERAND_WIDTH-1:0]      s_den_b,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [rau_pkg::NUM_OUT_W-1:0] m_res_num,
    input  logic [rau_pkg::DEN_OUT_W-1:0]        m_res_den,
    input  logic [rau_pkg::CODE_W-1:0]           m_order,
    input  logic [rau_pkg::CODE_W-1:0]           m_status,
    output int                                   fail_count,
    output int                                   pending_count
);

    import rau_pkg::*;

    typedef struct packed {
        logic [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0] den;
        logic [CODE_W-1:0]    ord;
        logic [CODE_W-1:0]    st;
    } fraction_result_t;

    fraction_result_t expected_fractions[$];

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Work out the result using signed 64-bit arithmetic, exact at this width
    function automatic fraction_result_t predict_fraction(logic [CMD_W-1:0] cmd,
            longint na, longint da, longint nb, longint db);
        fraction_result_t r;
        longint rn, rd, lcm, left, right;
        longint unsigned g, mag;
        r = '0;
        if (cmd > CMD_REDUCE) return r;
        if (da < 0) begin na = -na; da = -da; end
        if (db < 0) begin nb = -nb; db = -db; end
        if (da == 0 || (cmd != CMD_REDUCE && db == 0)) begin
            r.st = ST_ZERO_DEN;
            return r;
        end
        case (cmd)
            CMD_ADD, CMD_SUB: begin
                lcm = (da / longint'(gcd_of(da, db))) * db;
                rn = (cmd == CMD_SUB) ? na * (lcm / da) - nb * (lcm / db)
                                      : na * (lcm / da) + nb * (lcm / db);
                rd = lcm;
            end
            CMD_MUL: begin rn = na * nb; rd = da * db; end
            CMD_DIV: begin
                if (nb == 0) begin
                    r.st = ST_DIV_ZERO;
                    return r;
                end
                rn = na * db; rd = da * nb;
                if (rd < 0) begin rn = -rn; rd = -rd; end
            end
            CMD_CMP: begin
                left = na * db; right = nb * da;
                r.ord = (left < right) ? ORD_LESS : (left == right) ? ORD_EQUAL : ORD_GREATER;
                return r;
            end
            default: begin rn = na; rd = da; end
        endcase
        mag = (rn < 0) ? -rn : rn;
        g = gcd_of(mag, rd);
        if (g != 0) begin
            rn = rn / longint'(g);
            rd = rd / longint'(g);
        end
        r.num = rn[NUM_OUT_W-1:0];
        r.den = rd[DEN_OUT_W-1:0];
        return r;
    endfunction

    // Queue a prediction per accepted operand transaction, compare each result
    always @(posedge aclk) begin
        fraction_result_t exp_r;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_fractions.push_back(predict_fraction(s_cmd, s_num_a, s_den_a,
                                                              s_num_b, s_den_b));
            if (m_valid && m_ready) begin
                if (expected_fractions.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d ord=%0d st=%0d",
                             $time, m_res_num, m_res_den, m_order, m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_fractions.pop_front();
                    if (exp_r.num !== m_res_num || exp_r.den !== m_res_den ||
                        exp_r.ord !== m_order || exp_r.st !== m_status) begin
                        $display({"%0t: mismatch expected num=%0d den=%0d ord=%0d st=%0d,",
                                  " actual num=%0d den=%0d ord=%0d st=%0d"},
                                 $time, $signed(exp_r.num), exp_r.den, exp_r.ord,
                                 exp_r.st, m_res_num, m_res_den, m_order, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= expected_fractions.size();
    end

endmodule

>>> tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner cases and random fraction pairs with random gaps and
// result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int OPW        = 16;
    localparam int RAND_ITEMS = 1750;
    localparam int CYCLE_CAP  = 20000000;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [CMD_W-1:0] s_cmd;
    logic signed [OPW-1:0] s_num_a, s_den_a, s_num_b, s_den_b;
    logic signed [NUM_OUT_W-1:0] m_res_num;
    logic [DEN_OUT_W-1:0] m_res_den;
    logic [CODE_W-1:0] m_order, m_status;
    int fail_count, pending_count, cycles;

    rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) DUT (.*);

    rational_arithmetic_unit_checker #(.OPERAND_WIDTH(OPW)) checker_i (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Run a cycle counter as a watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result channel for a random time before each result is taken
    initial begin
        int stall;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic send_operands(logic [CMD_W-1:0] cmd, logic [OPW-1:0] na,
                                 logic [OPW-1:0] da, logic [OPW-1:0] nb,
                                 logic [OPW-1:0] db);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_cmd <= cmd; s_num_a <= na; s_den_a <= da; s_num_b <= nb; s_den_b <= db;
        @(posedge aclk iff s_ready);
    endtask

    function automatic logic [OPW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return OPW'($urandom_range(0, 15) - 8);
            1: return OPW'($urandom_range(0, 255) - 128);
            2: return OPW'({1'b1, {(OPW-1){1'b0}}} + $urandom_range(0, 3));
            3: return OPW'({1'b0, {(OPW-1){1'b1}}} - $urandom_range(0, 3));
            default: return OPW'($urandom());
        endcase
    endfunction

    initial begin
        logic [OPW-1:0] mn, mx, da, db;
        logic [CMD_W-1:0] c;
        mn = {1'b1, {(OPW-1){1'b0}}};
        mx = {1'b0, {(OPW-1){1'b1}}};
        aresetn = 0; s_valid = 0; s_cmd = 0;
        s_num_a = 0; s_den_a = 1; s_num_b = 0; s_den_b = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed corners: extremes, negative denominators, zero cases
        send_operands(CMD_ADD, mx, mx, mn, mn);
        send_operands(CMD_ADD, mn, 16'd1, mn, 16'd1);
        send_operands(CMD_SUB, mn, 16'd1, mx, 16'd1);
        send_operands(CMD_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
        send_operands(CMD_MUL, mn, 16'd1, mn, 16'd1);
        send_operands(CMD_MUL, 16'd3, -16'sd5, 16'd0, 16'd7);
        send_operands(CMD_DIV, mn, 16'd1, 16'd1, mn);
        send_operands(CMD_DIV, 16'd1, mx, mn, 16'd1);
        send_operands(CMD_DIV, 16'd5, 16'd3, 16'd0, -16'sd2);
        send_operands(CMD_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
        send_operands(CMD_CMP, -16'sd1, 16'd2, 16'd1, -16'sd3);
        send_operands(CMD_CMP, mx, mn, mn, mx);
        send_operands(CMD_CMP, 16'd0, 16'd5, 16'd0, -16'sd9);
        send_operands(CMD_REDUCE, 16'd12, -16'sd18, 16'd0, 16'd0);
        send_operands(CMD_REDUCE, mn, mn, 16'd7, 16'd0);
        send_operands(CMD_REDUCE, 16'd0, -16'sd4, mx, mx);
        send_operands(CMD_REDUCE, 16'd3, 16'd0, 16'd1, 16'd1);
        send_operands(CMD_ADD, 16'd1, 16'd1, 16'd1, 16'd0);
        send_operands(CMD_CMP, 16'd1, 16'd0, 16'd1, 16'd1);
        send_operands(3'd6, mx, mx, mx, mx);
        send_operands(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // Random operand pairs, rare zero denominators and unused codes
        repeat (RAND_ITEMS) begin
            c = ($urandom_range(0, 40) == 0) ? CMD_W'($urandom_range(6, 7))
                                             : CMD_W'($urandom_range(0, 5));
            da = rand_operand();
            db = rand_operand();
            if (da == 0 && $urandom_range(0, 9) != 0) da = 1;
            if (db == 0 && $urandom_range(0, 9) != 0) db = -1;
            send_operands(c, rand_operand(), da, rand_operand(), db);
        end
        s_valid <= 0;
        @(posedge aclk iff pending_count == 0);
        repeat (700) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
